// ===== hdl/ttrc_pkg.sv =====
// Package for the three-term recurrence checksum.
// Holds the word types and the fixed constants of the recurrence.
// No dependencies.
package ttrc_pkg;

	typedef logic [7:0]  byte_t;
	typedef logic [15:0] term_t;

	localparam term_t FIRST_OFFSET = 16'd7;
	localparam term_t MODULUS      = 16'hFFFF;

	// A multiple of the modulus that lifts any negative difference back above zero.
	localparam logic [25:0] NEG_BIAS = 26'd16842495;

endpackage

// ===== hdl/ttrc_if.sv =====
// Channel interfaces for the three-term recurrence checksum.
// Depends on ttrc_pkg for the word types.
interface ttrc_in_if;
	logic            valid;
	logic            ready;
	ttrc_pkg::byte_t data_byte;
	logic            last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ttrc_out_if;
	logic            valid;
	logic            ready;
	ttrc_pkg::term_t checksum;

	modport source (output valid, output checksum, input ready);
	modport sink (input valid, input checksum, output ready);
endinterface

// ===== hdl/ttrc_term.sv =====
// Next-term unit: ((byte + alpha) * current - beta * previous) mod 65535.
// A negative difference is taken as difference + 1 before the reduction.
// Depends on ttrc_pkg.
module ttrc_term (
	input  ttrc_pkg::byte_t data_byte,
	input  ttrc_pkg::byte_t position,
	input  ttrc_pkg::term_t curr_term,
	input  ttrc_pkg::term_t prev_term,
	output ttrc_pkg::term_t next_term
);
	import ttrc_pkg::*;

	byte_t       alpha;
	byte_t       beta;
	logic [8:0]  factor;
	logic [24:0] plus;
	logic [23:0] minus;
	logic [25:0] diff;
	logic [25:0] adj;
	logic [16:0] fold1;
	logic [16:0] fold2;
	logic [16:0] reduced;

	always_comb begin
		alpha  = position + {position[3:0], 4'b0000};
		beta   = {position[2:0], 5'b00000} - position;
		factor = {1'b0, data_byte} + {1'b0, alpha};
		plus   = {16'b0, factor} * {9'b0, curr_term};
		minus  = {8'b0, beta} * {8'b0, prev_term};
		diff   = {1'b0, plus} - {2'b00, minus};
		if (plus < {1'b0, minus}) begin
			adj = diff + 26'd1 + NEG_BIAS;
		end else begin
			adj = diff;
		end
		// Since 2^16 is 1 modulo 65535, the upper bits fold onto the lower ones.
		fold1 = {7'b0, adj[25:16]} + {1'b0, adj[15:0]};
		if (fold1[16]) begin
			fold2 = 17'd1 + {1'b0, fold1[15:0]};
		end else begin
			fold2 = fold1;
		end
		if (fold2 >= {1'b0, MODULUS}) begin
			reduced = fold2 - {1'b0, MODULUS};
		end else begin
			reduced = fold2;
		end
		next_term = reduced[15:0];
	end

endmodule

// ===== hdl/three_term_recurrence_checksum.sv =====
// Three-term recurrence checksum over a message streamed one byte per word.
// The last byte passes through the word register; its result then waits in the
// output register, and while that is full a last byte stays in the word register.
// Throughput: one word per cycle while no last byte is held back; the term
// recurrence closes combinationally through one next-term unit.
// Reset clears the word and output valid flags and the recurrence state at once.
module three_term_recurrence_checksum (
	input logic   clk,
	input logic   arst_n,
	ttrc_in_if.sink    message,
	ttrc_out_if.source result
);
	import ttrc_pkg::*;

	logic  valid_s1;
	byte_t data_s1;
	logic  last_s1;
	term_t prev_q;
	term_t curr_q;
	byte_t pos_q;
	logic  in_msg_q;
	logic  out_valid_q;
	term_t checksum_q;

	logic  out_free;
	logic  s1_fire;
	term_t term_next;
	term_t term_first;
	term_t term;

	ttrc_term u_term (
		.data_byte (data_s1),
		.position  (pos_q),
		.curr_term (curr_q),
		.prev_term (prev_q),
		.next_term (term_next)
	);

	assign out_free      = !out_valid_q || result.ready;
	assign s1_fire       = valid_s1 && (!last_s1 || out_free);
	assign message.ready = !valid_s1 || s1_fire;
	assign term_first    = {8'b0, data_s1} + FIRST_OFFSET;
	assign term          = in_msg_q ? term_next : term_first;
	assign result.valid    = out_valid_q;
	assign result.checksum = checksum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (message.ready) begin
			valid_s1 <= message.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (message.valid && message.ready) begin
			data_s1 <= message.data_byte;
			last_s1 <= message.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= 16'd1;
			curr_q   <= 16'd1;
			pos_q    <= 8'd0;
			in_msg_q <= 1'b0;
		end else if (s1_fire) begin
			if (last_s1) begin
				prev_q   <= 16'd1;
				curr_q   <= 16'd1;
				pos_q    <= 8'd0;
				in_msg_q <= 1'b0;
			end else begin
				prev_q   <= in_msg_q ? curr_q : 16'd1;
				curr_q   <= term;
				pos_q    <= in_msg_q ? pos_q + 8'd1 : 8'd1;
				in_msg_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_fire && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && last_s1) begin
			checksum_q <= term;
		end
	end

	a_rose_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s1_fire && last_s1))
		else $error("result raised without a last byte");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && last_s1) |=> (!in_msg_q && pos_q == 8'd0 && curr_q == 16'd1))
		else $error("recurrence state not cleared after a last byte");

	a_term_range: assert property (@(posedge clk) disable iff (!arst_n)
		(curr_q != MODULUS) && (!out_valid_q || checksum_q != MODULUS))
		else $error("term out of range");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!message.ready) |-> (valid_s1 && last_s1 && !out_free))
		else $error("input stalled without a blocked result");

endmodule

// ===== sim/tb_three_term_recurrence_checksum.sv =====
`timescale 1ns / 100ps
// Testbench for three_term_recurrence_checksum: byte-streamed messages in, checksums out.
// It predicts every checksum itself and compares each one with what the block returns.
// Depends on ttrc_pkg, ttrc_if and the block's RTL.
module tb_three_term_recurrence_checksum;
	import ttrc_pkg::*;

	localparam int ALPHA_STEP     = 17;
	localparam int BETA_STEP      = 31;
	localparam int RANDOM_BYTES   = 580;
	localparam int DRAIN_CYCLES   = 10;
	localparam int WATCHDOG_LIMIT = 2000;

	logic clk;
	logic arst_n;

	ttrc_in_if  msg_if ();
	ttrc_out_if res_if ();

	three_term_recurrence_checksum u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.message(msg_if),
		.result (res_if)
	);

	term_t run_prev;
	term_t run_curr;
	byte_t run_pos;
	logic  run_active;
	term_t expected_sums[$];

	int send_idle_pct;
	int recv_idle_pct;
	int error_count;
	int bytes_accepted;
	int messages_accepted;
	int sums_checked;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic term_t recurrence_term(byte_t b, byte_t pos, term_t curr, term_t prev);
		logic [7:0]  alpha;
		logic [7:0]  beta;
		logic [63:0] plus;
		logic [63:0] minus;
		logic [63:0] wrap;
		alpha = 8'(pos * ALPHA_STEP);
		beta  = 8'(pos * BETA_STEP);
		plus  = (64'(b) + 64'(alpha)) * 64'(curr);
		minus = 64'(beta) * 64'(prev);
		if (plus >= minus) begin
			return term_t'((plus - minus) % 64'(MODULUS));
		end
		wrap = (minus - plus - 64'd1) % 64'(MODULUS);
		return (wrap == 64'd0) ? term_t'(0) : term_t'(64'(MODULUS) - wrap);
	endfunction

	function automatic void checksum_advance(byte_t b, logic last_in);
		term_t term;
		if (!run_active) begin
			run_prev   = term_t'(1);
			run_curr   = term_t'(b) + FIRST_OFFSET;
			run_pos    = 8'd1;
			run_active = 1'b1;
			term       = run_curr;
		end else begin
			term     = recurrence_term(b, run_pos, run_curr, run_prev);
			run_prev = run_curr;
			run_curr = term;
			run_pos  = run_pos + 8'd1;
		end
		if (last_in) begin
			expected_sums.push_back(term);
			run_prev   = term_t'(1);
			run_curr   = term_t'(1);
			run_pos    = 8'd0;
			run_active = 1'b0;
		end
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		error_count++;
	endtask

	always @(posedge clk) begin : check_results
		term_t want;
		if (res_if.valid && res_if.ready) begin
			if (expected_sums.size() == 0) begin
				report_mismatch($sformatf("checksum %0d with none pending", res_if.checksum));
			end else begin
				want = expected_sums.pop_front();
				sums_checked++;
				if (res_if.checksum !== want) begin
					report_mismatch($sformatf("checksum %0d, predicted %0d",
						res_if.checksum, want));
				end
			end
		end
		if (msg_if.valid && msg_if.ready) begin
			checksum_advance(msg_if.data_byte, msg_if.last_byte);
			bytes_accepted++;
			if (msg_if.last_byte) begin
				messages_accepted++;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((msg_if.valid && msg_if.ready) || (res_if.valid && res_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no word moved for %0d cycles.", WATCHDOG_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_word(input byte_t b, input logic last_in);
		while ($urandom_range(99) < send_idle_pct) begin
			msg_if.valid <= 1'b0;
			@(negedge clk);
		end
		msg_if.valid     <= 1'b1;
		msg_if.data_byte <= b;
		msg_if.last_byte <= last_in;
		@(posedge clk);
		while (!msg_if.ready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic send_random_message(input int len);
		for (int i = 0; i < len; i++) begin
			send_word(byte_t'($urandom_range(255)), i == len - 1);
		end
	endtask

	task automatic test_single_byte_messages();
		send_word(8'h00, 1'b1);
		send_word(8'hFF, 1'b1);
		send_word(8'hA5, 1'b1);
		send_word(8'h5A, 1'b1);
	endtask

	task automatic test_two_byte_message();
		send_word(8'hFF, 1'b0);
		send_word(8'hFF, 1'b1);
	endtask

	// Zero bytes up to position 16, where alpha is small and beta large, push the
	// difference toward the negative side.
	task automatic test_zero_run();
		for (int i = 0; i < 17; i++) begin
			send_word(8'h00, i == 16);
		end
	endtask

	// Each phase opens with a message longer than 256 bytes so the position wraps.
	task automatic test_random_messages(input int send_pct, input int recv_pct);
		int start_bytes;
		int len;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		start_bytes   = bytes_accepted;
		send_random_message($urandom_range(257, 300));
		while (bytes_accepted - start_bytes < RANDOM_BYTES) begin
			if ($urandom_range(23) == 0) begin
				len = $urandom_range(257, 300);
			end else if ($urandom_range(1)) begin
				len = $urandom_range(1, 8);
			end else begin
				len = $urandom_range(9, 40);
			end
			send_random_message(len);
		end
	endtask

	initial begin
		arst_n            = 1'b0;
		msg_if.valid      = 1'b0;
		msg_if.data_byte  = '0;
		msg_if.last_byte  = 1'b0;
		res_if.ready      = 1'b0;
		run_prev          = term_t'(1);
		run_curr          = term_t'(1);
		run_pos           = 8'd0;
		run_active        = 1'b0;
		send_idle_pct     = 33;
		recv_idle_pct     = 55;
		error_count       = 0;
		bytes_accepted    = 0;
		messages_accepted = 0;
		sums_checked      = 0;
		quiet_cycles      = 0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_single_byte_messages();
		test_two_byte_message();
		test_zero_run();
		test_random_messages(33, 55);
		test_random_messages(55, 33);
		test_random_messages(0, 0);

		msg_if.valid <= 1'b0;
		@(negedge clk);
		while (expected_sums.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d bytes in %0d messages and checked %0d checksums,",
			bytes_accepted, messages_accepted, sums_checked);
		$display("with idle mixes of 33/55, 55/33 and none on the two channels.");
		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
